/* sv/erk_pkg.sv */
// ----------------------------------------------------------------------------
// erk_pkg
// Shared types, constants and tables for the Euler angle rate block.
// ----------------------------------------------------------------------------
`default_nettype none

package erk_pkg;

	localparam int CORDIC_ITERATIONS_DEF = 24;
	localparam int ZW = 36;
	localparam int DIV_QBITS = 33;
	localparam int DVD_W = 63;
	localparam int DVS_W = 31;

	localparam logic signed [ZW-1:0] GAIN_Q32 = 36'sh09B74EDA8;
	localparam logic signed [ZW-1:0] PI_Q32 = 36'sh3243F6A89;
	localparam logic signed [ZW-1:0] HALF_PI_Q32 = 36'sh1921FB544;
	localparam logic signed [31:0] ONE_Q30 = 32'sh40000000;

	localparam logic [2:0] ORD_132 = 3'd0;
	localparam logic [2:0] ORD_321 = 3'd1;
	localparam logic [2:0] ORD_312 = 3'd2;
	localparam logic [2:0] ORD_213 = 3'd3;
	localparam logic [2:0] ORD_123 = 3'd4;
	localparam logic [2:0] ORD_231 = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_SINGULAR = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_MIN_COS = 1'b1;
	localparam logic [30:0] RESET_MIN_COS = 31'd1073742;

	typedef logic signed [31:0] word_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
	} rate3_t;

	typedef struct packed {
		logic [1:0] pos_q1;
		logic [1:0] pos_q2;
		logic [1:0] pos_b;
		logic neg_q1;
		logic neg_q2;
		word_t base;
		logic signed [33:0] b_term;
		logic [1:0] status;
	} side_t;

	function automatic logic signed [ZW-1:0] atan_q32(input int unsigned i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = 36'sd3373259426;
			1: v = 36'sd1991351318;
			2: v = 36'sd1052175346;
			3: v = 36'sd534100635;
			4: v = 36'sd268086748;
			5: v = 36'sd134174063;
			6: v = 36'sd67103403;
			7: v = 36'sd33553749;
			8: v = 36'sd16777131;
			9: v = 36'sd8388597;
			10: v = 36'sd4194303;
			11: v = 36'sd2097152;
			12: v = 36'sd1048576;
			13: v = 36'sd524288;
			14: v = 36'sd262144;
			15: v = 36'sd131072;
			16: v = 36'sd65536;
			17: v = 36'sd32768;
			18: v = 36'sd16384;
			19: v = 36'sd8192;
			20: v = 36'sd4096;
			21: v = 36'sd2048;
			22: v = 36'sd1024;
			23: v = 36'sd512;
			24: v = 36'sd256;
			25: v = 36'sd128;
			26: v = 36'sd64;
			27: v = 36'sd32;
			28: v = 36'sd16;
			29: v = 36'sd8;
			30: v = 36'sd4;
			31: v = 36'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic word_t sat32(input logic signed [35:0] v);
		word_t r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/euler_rate_from_body_rate.sv */
// ----------------------------------------------------------------------------
// euler_rate_from_body_rate
// Euler angle rates from body angular rates for six rotation orders.
// ----------------------------------------------------------------------------
// Input beats carry three Euler angles (Q3.29) and three body rates (Q4.28)
// on the s_axis channel. Each input beat gives exactly one output beat on
// m_axis with three Euler angle rates (Q4.28, saturated) and a status code.
// The rotation order and the minimum divisor cosine are set through the
// cfg port; the user must write them only while the block is idle, and
// the block itself does not enforce this. A new beat is accepted every
// cycle while s_axis_tready is high. The pipeline has one CORDIC stage per
// iteration and one divider stage per quotient bit.
// Reset empties the pipeline and loads the default configuration.
// When the receiver stalls, one more result is caught in a skid register,
// after which the whole pipeline holds and s_axis_tready drops; nothing is
// lost or repeated. s_axis_tready never depends on m_axis_tready directly.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_rate_from_body_rate #(
	parameter int CORDIC_ITERATIONS = erk_pkg::CORDIC_ITERATIONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [30:0]   cfg_wdata,
	input  wire logic          s_axis_tvalid,
	output logic               s_axis_tready,
	// angle_first, angle_second, angle_third, body_rate_x, body_rate_y, body_rate_z
	input  wire logic [191:0]  s_axis_tdata,
	output logic               m_axis_tvalid,
	input  wire logic          m_axis_tready,
	// rate_first, rate_second, rate_third, status, zero padding
	output logic [103:0]       m_axis_tdata
);

	logic [2:0] order_q;
	logic [30:0] min_cos_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= erk_pkg::ORD_132;
			min_cos_q <= erk_pkg::RESET_MIN_COS;
		end else if (cfg_we) begin
			case (cfg_index)
				erk_pkg::REG_ORDER: order_q <= cfg_wdata[2:0];
				erk_pkg::REG_MIN_COS: min_cos_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic in_valid;
	logic [2:0][31:0] in_ang;
	erk_pkg::rate3_t in_rate;

	assign in_valid = s_axis_tvalid & en;
	assign in_ang = s_axis_tdata[95:0];
	assign in_rate.x = s_axis_tdata[127:96];
	assign in_rate.y = s_axis_tdata[159:128];
	assign in_rate.z = s_axis_tdata[191:160];

	logic sc_valid;
	logic [2:0][31:0] sc_sin;
	logic [2:0][31:0] sc_cos;
	erk_pkg::rate3_t sc_rate;

	erk_sincos #(
		.ITER(CORDIC_ITERATIONS)
	) u_sincos (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(in_valid),
		.ang(in_ang),
		.in_rate(in_rate),
		.out_valid(sc_valid),
		.sin_o(sc_sin),
		.cos_o(sc_cos),
		.out_rate(sc_rate)
	);

	erk_pkg::word_t s1, c1, s2, c2, s3, c3;
	erk_pkg::word_t ta0, ua0, ta1, ua1, tb0, ub0, tb1, ub1, dv, nm, base, dvm;
	logic a_sub, b_sub, n1, n2;
	logic [1:0] p1, p2, pb, st;

	assign s1 = sc_sin[0];
	assign c1 = sc_cos[0];
	assign s2 = sc_sin[1];
	assign c2 = sc_cos[1];
	assign s3 = sc_sin[2];
	assign c3 = sc_cos[2];

	always_comb begin
		ta0 = c2; ua0 = sc_rate.x; ta1 = s2; ua1 = sc_rate.z; a_sub = 1'b0;
		tb0 = c2; ub0 = sc_rate.z; tb1 = s2; ub1 = sc_rate.x; b_sub = 1'b1;
		dv = c3; nm = s3; base = sc_rate.y;
		p1 = 2'd0; p2 = 2'd1; pb = 2'd2; n1 = 1'b0; n2 = 1'b0;
		case (order_q)
			erk_pkg::ORD_132: ;
			erk_pkg::ORD_321: begin
				ta0 = s1; ua0 = sc_rate.y; ta1 = c1; ua1 = sc_rate.z; a_sub = 1'b0;
				tb0 = c1; ub0 = sc_rate.y; tb1 = s1; ub1 = sc_rate.z; b_sub = 1'b1;
				dv = c2; nm = s2; base = sc_rate.x;
				p2 = 2'd0; pb = 2'd1; p1 = 2'd2;
			end
			erk_pkg::ORD_312: begin
				ta0 = s2; ua0 = sc_rate.x; ta1 = c2; ua1 = sc_rate.z; a_sub = 1'b1;
				tb0 = c2; ub0 = sc_rate.x; tb1 = s2; ub1 = sc_rate.z; b_sub = 1'b0;
				dv = c1; nm = s1; base = sc_rate.y;
				pb = 2'd0; p2 = 2'd1; p1 = 2'd2; n1 = 1'b1;
			end
			erk_pkg::ORD_213: begin
				ta0 = s3; ua0 = sc_rate.x; ta1 = c3; ua1 = sc_rate.y; a_sub = 1'b0;
				tb0 = c3; ub0 = sc_rate.x; tb1 = s3; ub1 = sc_rate.y; b_sub = 1'b1;
				dv = c1; nm = s1; base = sc_rate.z;
				pb = 2'd0; p1 = 2'd1; p2 = 2'd2;
			end
			erk_pkg::ORD_123: begin
				ta0 = c3; ua0 = sc_rate.x; ta1 = s3; ua1 = sc_rate.y; a_sub = 1'b1;
				tb0 = c3; ub0 = sc_rate.y; tb1 = s3; ub1 = sc_rate.x; b_sub = 1'b0;
				dv = c2; nm = s2; base = sc_rate.z;
				p1 = 2'd0; pb = 2'd1; p2 = 2'd2; n2 = 1'b1;
			end
			erk_pkg::ORD_231: begin
				ta0 = c1; ua0 = sc_rate.y; ta1 = s1; ua1 = sc_rate.z; a_sub = 1'b1;
				tb0 = c1; ub0 = sc_rate.z; tb1 = s1; ub1 = sc_rate.y; b_sub = 1'b0;
				dv = c3; nm = s3; base = sc_rate.x;
				p2 = 2'd0; p1 = 2'd1; pb = 2'd2; n2 = 1'b1;
			end
			default: ;
		endcase
		dvm = dv[31] ? -dv : dv;
		if (order_q > erk_pkg::ORD_231) begin
			st = erk_pkg::ST_INVALID;
		end else if (dv == '0 || dvm < {1'b0, min_cos_q}) begin
			st = erk_pkg::ST_SINGULAR;
		end else begin
			st = erk_pkg::ST_OK;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [63:0] pa0_s1, pa1_s1, pb0_s1, pb1_s1;
	logic a_sub_s1, b_sub_s1;
	erk_pkg::word_t dv_s1, nm_s1;
	erk_pkg::side_t side_s1, side_s2, side_s3, side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pa0_s1 <= ta0 * ua0;
			pa1_s1 <= ta1 * ua1;
			pb0_s1 <= tb0 * ub0;
			pb1_s1 <= tb1 * ub1;
			a_sub_s1 <= a_sub;
			b_sub_s1 <= b_sub;
			dv_s1 <= dv;
			nm_s1 <= nm;
			side_s1.pos_q1 <= p1;
			side_s1.pos_q2 <= p2;
			side_s1.pos_b <= pb;
			side_s1.neg_q1 <= n1;
			side_s1.neg_q2 <= n2;
			side_s1.base <= base;
			side_s1.b_term <= '0;
			side_s1.status <= st;
		end
	end

	logic signed [63:0] a_sum, b_sum, a_abs, b_abs, b_quo;
	erk_pkg::word_t s_abs, c_abs;
	erk_pkg::side_t side_nx;

	always_comb begin
		a_sum = a_sub_s1 ? (pa0_s1 - pa1_s1) : (pa0_s1 + pa1_s1);
		b_sum = b_sub_s1 ? (pb0_s1 - pb1_s1) : (pb0_s1 + pb1_s1);
		a_abs = a_sum[63] ? -a_sum : a_sum;
		b_abs = b_sum[63] ? -b_sum : b_sum;
		b_quo = b_abs >> 30;
		if (b_sum[63]) begin
			b_quo = -b_quo;
		end
		s_abs = nm_s1[31] ? -nm_s1 : nm_s1;
		c_abs = dv_s1[31] ? -dv_s1 : dv_s1;
		side_nx = side_s1;
		side_nx.neg_q1 = side_s1.neg_q1 ^ a_sum[63] ^ dv_s1[31];
		side_nx.neg_q2 = side_s1.neg_q2 ^ a_sum[63] ^ nm_s1[31] ^ dv_s1[31];
		side_nx.b_term = b_quo[33:0];
	end

	logic [62:0] amag_s2, amag_s3, amag_s4;
	logic [30:0] smag_s2, cmag_s2, cmag_s3, cmag_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			amag_s2 <= a_abs[62:0];
			smag_s2 <= s_abs[30:0];
			cmag_s2 <= c_abs[30:0];
			side_s2 <= side_nx;
		end
	end

	logic [62:0] phi_s3;
	logic [61:0] plo_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s3 <= {31'b0, amag_s2[62:31]} * {32'b0, smag_s2};
			plo_s3 <= {31'b0, amag_s2[30:0]} * {31'b0, smag_s2};
			amag_s3 <= amag_s2;
			cmag_s3 <= cmag_s2;
			side_s3 <= side_s2;
		end
	end

	logic [93:0] prod_sum;
	logic [62:0] p_s4;

	assign prod_sum = {phi_s3, 31'b0} + {32'b0, plo_s3};

	always_ff @(posedge clk) begin
		if (en) begin
			p_s4 <= prod_sum[92:30];
			amag_s4 <= amag_s3;
			cmag_s4 <= cmag_s3;
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sc_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	logic dq_valid;
	logic [33:0] dq_a, dq_p;
	erk_pkg::side_t dq_side;

	erk_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s4),
		.dvd_a(amag_s4),
		.dvd_p(p_s4),
		.dvs(cmag_s4),
		.in_side(side_s4),
		.out_valid(dq_valid),
		.quo_a(dq_a),
		.quo_p(dq_p),
		.out_side(dq_side)
	);

	logic signed [35:0] q1x, q2x, q1s, q2s, bsx, btx;
	erk_pkg::word_t res [3];

	always_comb begin
		logic signed [35:0] sum;
		q1x = $signed({2'b00, dq_a});
		q2x = $signed({2'b00, dq_p});
		q1s = dq_side.neg_q1 ? -q1x : q1x;
		q2s = dq_side.neg_q2 ? -q2x : q2x;
		bsx = 36'(dq_side.base);
		btx = 36'(dq_side.b_term);
		for (int k = 0; k < 3; k++) begin
			if (dq_side.pos_b == 2'(k)) begin
				sum = btx;
			end else if (dq_side.pos_q1 == 2'(k)) begin
				sum = q1s;
			end else begin
				sum = bsx + q2s;
			end
			res[k] = (dq_side.status == erk_pkg::ST_OK) ? erk_pkg::sat32(sum) : '0;
		end
	end

	logic [97:0] res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= {dq_side.status, res[2], res[1], res[0]};
		end
	end

	logic out_valid_q, skid_valid_q, out_free;
	logic [97:0] out_q, skid_q;

	assign out_free = ~out_valid_q | m_axis_tready;
	assign en = ~skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= v_s5;
		end else if (v_s5) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (out_free) begin
			out_q <= res_s5;
		end else begin
			skid_q <= res_s5;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {6'b0, out_q};

endmodule

`default_nettype wire

/* sv/erk_sincos.sv */
// ----------------------------------------------------------------------------
// erk_sincos
// Three-lane pipelined CORDIC giving sine and cosine of three angles.
// ----------------------------------------------------------------------------
`default_nettype none

module erk_sincos #(
	parameter int ITER = erk_pkg::CORDIC_ITERATIONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [2:0][31:0]     ang,
	input  wire erk_pkg::rate3_t      in_rate,
	output logic                      out_valid,
	output logic [2:0][31:0]          sin_o,
	output logic [2:0][31:0]          cos_o,
	output erk_pkg::rate3_t           out_rate
);

	localparam int ZW = erk_pkg::ZW;
	localparam logic signed [ZW-1:0] ONE_Z = ZW'(erk_pkg::ONE_Q30);

	logic [ITER+1:0] v_s;
	erk_pkg::rate3_t rate_s [ITER+2];
	erk_pkg::word_t sin_s [3];
	erk_pkg::word_t cos_s [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[ITER:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rate_s[0] <= in_rate;
			for (int k = 1; k < ITER + 2; k++) begin
				rate_s[k] <= rate_s[k-1];
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic signed [ZW-1:0] x_s [ITER+1];
		logic signed [ZW-1:0] y_s [ITER+1];
		logic signed [ZW-1:0] z_s [ITER+1];
		logic [ITER:0] flip_s;
		logic signed [ZW-1:0] z_in;
		logic signed [ZW-1:0] z_red;
		logic flip_in;
		logic signed [ZW-1:0] xf;
		logic signed [ZW-1:0] yf;
		logic signed [ZW-1:0] xr;
		logic signed [ZW-1:0] yr;

		always_comb begin
			z_in = {{(ZW-35){ang[l][31]}}, ang[l], 3'b000};
			z_red = z_in;
			flip_in = 1'b0;
			if (z_in > erk_pkg::HALF_PI_Q32) begin
				z_red = z_in - erk_pkg::PI_Q32;
				flip_in = 1'b1;
			end else if (z_in < -erk_pkg::HALF_PI_Q32) begin
				z_red = z_in + erk_pkg::PI_Q32;
				flip_in = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0] <= erk_pkg::GAIN_Q32;
				y_s[0] <= '0;
				z_s[0] <= z_red;
				flip_s[0] <= flip_in;
			end
		end

		for (genvar i = 0; i < ITER; i++) begin : g_iter
			localparam logic signed [ZW-1:0] AT = erk_pkg::atan_q32(i);
			always_ff @(posedge clk) begin
				if (en) begin
					if (z_s[i] >= 0) begin
						x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] - AT;
					end else begin
						x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
						y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
						z_s[i+1] <= z_s[i] + AT;
					end
					flip_s[i+1] <= flip_s[i];
				end
			end
		end

		always_comb begin
			xf = flip_s[ITER] ? -x_s[ITER] : x_s[ITER];
			yf = flip_s[ITER] ? -y_s[ITER] : y_s[ITER];
			xr = (xf + ZW'(2)) >>> 2;
			yr = (yf + ZW'(2)) >>> 2;
			if (xr > ONE_Z) begin
				xr = ONE_Z;
			end else if (xr < -ONE_Z) begin
				xr = -ONE_Z;
			end
			if (yr > ONE_Z) begin
				yr = ONE_Z;
			end else if (yr < -ONE_Z) begin
				yr = -ONE_Z;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cos_s[l] <= xr[31:0];
				sin_s[l] <= yr[31:0];
			end
		end

		assign sin_o[l] = sin_s[l];
		assign cos_o[l] = cos_s[l];
	end

	assign out_valid = v_s[ITER+1];
	assign out_rate = rate_s[ITER+1];

endmodule

`default_nettype wire

/* sv/erk_div.sv */
// ----------------------------------------------------------------------------
// erk_div
// Two-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage, quotient capped on overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module erk_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [erk_pkg::DVD_W-1:0]     dvd_a,
	input  wire logic [erk_pkg::DVD_W-1:0]     dvd_p,
	input  wire logic [erk_pkg::DVS_W-1:0]     dvs,
	input  wire erk_pkg::side_t                in_side,
	output logic                               out_valid,
	output logic [erk_pkg::DIV_QBITS:0]        quo_a,
	output logic [erk_pkg::DIV_QBITS:0]        quo_p,
	output erk_pkg::side_t                     out_side
);

	localparam int QB = erk_pkg::DIV_QBITS;
	localparam int DW = erk_pkg::DVD_W;
	localparam int CW = erk_pkg::DVS_W;

	logic [QB:0] v_s;
	erk_pkg::side_t side_s [QB+1];
	logic [CW-1:0] c_s [QB+1];
	logic [1:0][DW-1:0] dvd;
	logic [1:0][QB:0] quo_w;

	assign dvd = {dvd_p, dvd_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[QB-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			c_s[0] <= dvs;
			for (int k = 1; k <= QB; k++) begin
				side_s[k] <= side_s[k-1];
				c_s[k] <= c_s[k-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [DW-1:0] d_s [QB+1];
		logic [CW:0] r_s [QB+1];
		logic [QB-1:0] q_s [QB+1];
		logic [QB:0] ovf_s;

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[0] <= dvd[l];
				r_s[0] <= (CW+1)'(dvd[l][DW-1:QB]);
				q_s[0] <= '0;
				ovf_s[0] <= (CW'(dvd[l][DW-1:QB]) >= dvs);
			end
		end

		for (genvar k = 1; k <= QB; k++) begin : g_step
			logic [CW:0] rt;
			logic ge;
			logic [QB-1:0] qn;

			always_comb begin
				rt = {r_s[k-1][CW-1:0], d_s[k-1][QB-k]};
				ge = (rt >= {1'b0, c_s[k-1]});
				qn = q_s[k-1];
				qn[QB-k] = ge;
			end

			always_ff @(posedge clk) begin
				if (en) begin
					d_s[k] <= d_s[k-1];
					r_s[k] <= ge ? (rt - {1'b0, c_s[k-1]}) : rt;
					q_s[k] <= qn;
					ovf_s[k] <= ovf_s[k-1];
				end
			end
		end

		assign quo_w[l] = ovf_s[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q_s[QB]};
	end

	assign out_valid = v_s[QB];
	assign out_side = side_s[QB];
	assign quo_a = quo_w[0];
	assign quo_p = quo_w[1];

endmodule

`default_nettype wire
